>>> sv/divisor_sum_sigma_top_assert.svh
// ---------------------------------------------------------------------------
// divisor_sum_sigma_top_assert: assertion macros
// concurrent checks that can be compiled out with ASSERT_OFF
// ---------------------------------------------------------------------------
`ifndef DIVISOR_SUM_SIGMA_TOP_ASSERT_SVH
`define DIVISOR_SUM_SIGMA_TOP_ASSERT_SVH

`ifndef ASSERT_OFF

`define DSS_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

`define DSS_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`else

`define DSS_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg)

`define DSS_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg)

`endif

`endif

>>> sv/dss_pkg.sv
// ---------------------------------------------------------------------------
// dss_pkg: divisor sum package
// widths, sequencer states and the shared unit control types
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

package dss_pkg;

  localparam int unsigned IN_W             = 32;
  localparam int unsigned SUM_W            = 35;
  localparam int unsigned NUMBER_WIDTH_DEF = 32;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CHECK,
    ST_DIV,
    ST_PMUL,
    ST_TMUL,
    ST_LAST,
    ST_FLUSH
  } dss_state_e;

  typedef enum logic {
    OP_MUL,
    OP_DIV
  } dss_op_e;

  typedef struct packed {
    logic    start;
    dss_op_e op;
  } dss_ctrl_t;

  typedef struct packed {
    logic busy;
    logic done;
  } dss_stat_t;

endpackage

>>> sv/divisor_sum_sigma_top.sv
// ---------------------------------------------------------------------------
// divisor_sum_sigma_top: sum of all positive divisors by trial division
// each trial divisor takes a division pass, each prime factor found a multiply
// and another division pass, each distinct prime a term multiply, and a prime
// left over one last multiply; each pass runs through the 35-step serial unit
// one item at a time; the next transfer is taken while the result waits
// reset: asynchronous, active low; clears sequencer and output valid
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "divisor_sum_sigma_top_assert.svh"

module divisor_sum_sigma_top #(
  parameter int unsigned NUMBER_WIDTH = dss_pkg::NUMBER_WIDTH_DEF
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      in_valid_i,
  output logic                      in_ready_o,
  input  logic [dss_pkg::IN_W-1:0]  number_in_i,
  output logic                      out_valid_o,
  input  logic                      out_ready_i,
  output logic [dss_pkg::SUM_W-1:0] divisor_sum_o
);

  import dss_pkg::*;

  localparam int unsigned NE  = (NUMBER_WIDTH < IN_W) ? NUMBER_WIDTH : IN_W;
  localparam int unsigned DW  = NE / 2 + 1;
  localparam int unsigned SQW = 2 * DW;

  dss_state_e       state_q, state_d;
  logic [NE-1:0]    rest_q, rest_d;
  logic [DW-1:0]    d_q, d_d;
  logic [SQW-1:0]   sq_q, sq_d;
  logic [NE-1:0]    power_q, power_d;
  logic [SUM_W-1:0] term_q, term_d;
  logic [SUM_W-1:0] total_q, total_d;
  logic [SUM_W-1:0] out_q, out_d;
  logic             out_valid_q, out_valid_d;

  dss_ctrl_t        unit_ctrl;
  dss_stat_t        unit_stat;
  logic [SUM_W-1:0] unit_a, unit_b, unit_hi, unit_lo;

  logic             sq_fits, rest_big, rem_zero, term_one, out_free;
  logic [SUM_W-1:0] term_sum;

  assign sq_fits  = sq_q <= SQW'(rest_q);
  assign rest_big = rest_q > NE'(1);
  assign rem_zero = unit_hi == '0;
  assign term_one = term_q == SUM_W'(1);
  assign out_free = !out_valid_q || out_ready_i;
  assign term_sum = term_q + unit_hi;

  dss_iter_unit #(
    .W (SUM_W)
  ) u_unit (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .ctrl_i (unit_ctrl),
    .a_i    (unit_a),
    .b_i    (unit_b),
    .stat_o (unit_stat),
    .hi_o   (unit_hi),
    .lo_o   (unit_lo)
  );

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) state_d = ST_CHECK;
      end
      ST_CHECK: begin
        if (sq_fits)       state_d = ST_DIV;
        else if (rest_big) state_d = ST_LAST;
        else               state_d = ST_FLUSH;
      end
      ST_DIV: begin
        if (unit_stat.done) begin
          if (rem_zero)       state_d = ST_PMUL;
          else if (!term_one) state_d = ST_TMUL;
          else                state_d = ST_CHECK;
        end
      end
      ST_PMUL: begin
        if (unit_stat.done) state_d = ST_DIV;
      end
      ST_TMUL: begin
        if (unit_stat.done) state_d = ST_CHECK;
      end
      ST_LAST: begin
        if (unit_stat.done) state_d = ST_FLUSH;
      end
      ST_FLUSH: begin
        if (out_free) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // outputs and datapath
  always_comb begin
    in_ready_o      = 1'b0;
    unit_ctrl.start = 1'b0;
    unit_ctrl.op    = OP_MUL;
    unit_a          = '0;
    unit_b          = '0;
    rest_d          = rest_q;
    d_d             = d_q;
    sq_d            = sq_q;
    power_d         = power_q;
    term_d          = term_q;
    total_d         = total_q;
    out_d           = out_q;
    out_valid_d     = out_valid_q && !out_ready_i;
    unique case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          rest_d  = number_in_i[NE-1:0];
          d_d     = DW'(2);
          sq_d    = SQW'(4);
          total_d = SUM_W'(1);
        end
      end
      ST_CHECK: begin
        if (sq_fits) begin
          unit_ctrl.start = 1'b1;
          unit_ctrl.op    = OP_DIV;
          unit_a          = SUM_W'(rest_q);
          unit_b          = SUM_W'(d_q);
          power_d         = NE'(1);
          term_d          = SUM_W'(1);
        end else if (rest_big) begin
          unit_ctrl.start = 1'b1;
          unit_a          = SUM_W'(rest_q) + SUM_W'(1);
          unit_b          = total_q;
        end
      end
      ST_DIV: begin
        if (unit_stat.done) begin
          if (rem_zero) begin
            rest_d          = unit_lo[NE-1:0];
            unit_ctrl.start = 1'b1;
            unit_a          = SUM_W'(power_q);
            unit_b          = SUM_W'(d_q);
          end else if (!term_one) begin
            unit_ctrl.start = 1'b1;
            unit_a          = term_q;
            unit_b          = total_q;
          end else begin
            d_d  = d_q + DW'(1);
            sq_d = sq_q + SQW'({d_q, 1'b1});
          end
        end
      end
      ST_PMUL: begin
        if (unit_stat.done) begin
          power_d         = unit_hi[NE-1:0];
          term_d          = term_sum;
          unit_ctrl.start = 1'b1;
          unit_ctrl.op    = OP_DIV;
          unit_a          = SUM_W'(rest_q);
          unit_b          = SUM_W'(d_q);
        end
      end
      ST_TMUL: begin
        if (unit_stat.done) begin
          total_d = unit_hi;
          d_d     = d_q + DW'(1);
          sq_d    = sq_q + SQW'({d_q, 1'b1});
        end
      end
      ST_LAST: begin
        if (unit_stat.done) total_d = unit_hi;
      end
      ST_FLUSH: begin
        if (out_free) begin
          out_d       = total_q;
          out_valid_d = 1'b1;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rest_q  <= rest_d;
    d_q     <= d_d;
    sq_q    <= sq_d;
    power_q <= power_d;
    term_q  <= term_d;
    total_q <= total_d;
    out_q   <= out_d;
  end

  assign out_valid_o   = out_valid_q;
  assign divisor_sum_o = out_q;

  `DSS_ASSERT_IMP(a_idle_unit_free, clk_i, rst_ni, state_q == ST_IDLE, !unit_stat.busy, "unit busy while idle")
  `DSS_ASSERT_NXT(a_accept_to_check, clk_i, rst_ni, in_valid_i && in_ready_o, state_q == ST_CHECK, "accepted item did not start")
  `DSS_ASSERT_IMP(a_done_in_wait, clk_i, rst_ni, unit_stat.done, state_q == ST_DIV || state_q == ST_PMUL || state_q == ST_TMUL || state_q == ST_LAST, "unit result outside a wait state")
  `DSS_ASSERT_IMP(a_sum_nonzero, clk_i, rst_ni, out_valid_o, divisor_sum_o != '0, "zero divisor sum")

endmodule

>>> sv/dss_iter_unit.sv
// ---------------------------------------------------------------------------
// dss_iter_unit: bit-serial multiply / divide unit
// one add/subtract per cycle, msb first; multiply gives the product in hi,
// divide gives the quotient in lo and the remainder in hi
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module dss_iter_unit #(
  parameter int unsigned W = dss_pkg::SUM_W
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  dss_pkg::dss_ctrl_t ctrl_i,
  input  logic [W-1:0]       a_i,
  input  logic [W-1:0]       b_i,
  output dss_pkg::dss_stat_t stat_o,
  output logic [W-1:0]       hi_o,
  output logic [W-1:0]       lo_o
);

  import dss_pkg::*;

  localparam int unsigned CW = (W > 1) ? $clog2(W) : 1;

  dss_op_e        op_q;
  logic [W-1:0]   acc_q, acc_d;
  logic [W-1:0]   lo_q, lo_d;
  logic [W-1:0]   b_q;
  logic           busy_q, busy_d;
  logic           done_q, done_d;
  logic [CW-1:0]  cnt_q, cnt_d;
  logic [W:0]     x, y, sum;

  always_comb begin
    x   = {acc_q, (op_q == OP_DIV) ? lo_q[W-1] : 1'b0};
    y   = ((op_q == OP_DIV) || lo_q[W-1]) ? {1'b0, b_q} : '0;
    sum = (op_q == OP_DIV) ? (x - y) : (x + y);
  end

  always_comb begin
    acc_d  = acc_q;
    lo_d   = lo_q;
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    if (ctrl_i.start) begin
      acc_d  = '0;
      lo_d   = a_i;
      busy_d = 1'b1;
      cnt_d  = '0;
    end else if (busy_q) begin
      if (op_q == OP_DIV) begin
        acc_d = sum[W] ? x[W-1:0] : sum[W-1:0];
        lo_d  = {lo_q[W-2:0], ~sum[W]};
      end else begin
        acc_d = sum[W-1:0];
        lo_d  = {lo_q[W-2:0], 1'b0};
      end
      cnt_d = cnt_q + CW'(1);
      if (cnt_q == CW'(W - 1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    acc_q <= acc_d;
    lo_q  <= lo_d;
    if (ctrl_i.start) begin
      op_q <= ctrl_i.op;
      b_q  <= b_i;
    end
  end

  assign stat_o.busy = busy_q;
  assign stat_o.done = done_q;
  assign hi_o        = acc_q;
  assign lo_o        = lo_q;

endmodule
